@@ design/rolt_pkg.sv @@
// Shared constants, codes and types of the resource ownership lock table.
package rolt_pkg;

  localparam int PIN_ENTRIES   = 64;
  localparam int TIMER_ENTRIES = 9;

  localparam int PIN_AW  = (PIN_ENTRIES > 1) ? $clog2(PIN_ENTRIES) : 1;
  localparam int TMR_AW  = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
  localparam int IDX_W   = 6;
  localparam int OWNER_W = 3;
  localparam int UNIT_W  = 8;
  localparam int ENTRY_W = OWNER_W + UNIT_W;

  localparam logic [OWNER_W-1:0] OWNER_FREE   = 3'd0;
  localparam logic [OWNER_W-1:0] OWNER_SYSTEM = 3'd1;

  localparam logic [1:0] ST_GRANTED   = 2'd0;
  localparam logic [1:0] ST_HELD      = 2'd1;
  localparam logic [1:0] ST_NONE_FREE = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic OP_LOCK    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic CLS_PIN   = 1'b0;
  localparam logic CLS_TIMER = 1'b1;

  // bitmap update from the execute cycle
  typedef struct packed {
    logic               set;
    logic               cls;
    logic [IDX_W-1:0]   idx;
    logic [OWNER_W-1:0] who;
  } bm_upd_t;

  // per-entry flags of the addressed entry
  typedef struct packed {
    logic used;
    logic known;
  } bm_entry_t;

endpackage

@@ design/rolt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rolt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ design/rolt_bitmap.sv @@
// Occupancy bitmaps of both tables with first-free search and pin release.
module rolt_bitmap
  import rolt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             find_cls,
  output logic             free_found,
  output logic [IDX_W-1:0] free_idx,
  input  logic             ent_cls,
  input  logic [IDX_W-1:0] ent_idx,
  output bm_entry_t        ent,
  input  bm_upd_t          upd,
  input  logic             release_all
);

  logic [PIN_ENTRIES-1:0]   pin_used_r, pin_used_nxt;
  logic [PIN_ENTRIES-1:0]   pin_sys_r, pin_sys_nxt;
  logic [TIMER_ENTRIES-1:0] tmr_used_r, tmr_used_nxt;
  logic [TIMER_ENTRIES-1:0] tmr_known_r, tmr_known_nxt;
  logic [IDX_W-1:0]         pin_free_idx, tmr_free_idx;

  // lowest free entry wins
  always_comb begin
    pin_free_idx = '0;
    for (int i = PIN_ENTRIES - 1; i >= 0; i--) begin
      if (!pin_used_r[i]) begin
        pin_free_idx = IDX_W'(i);
      end
    end
    tmr_free_idx = '0;
    for (int i = TIMER_ENTRIES - 1; i >= 0; i--) begin
      if (!tmr_used_r[i]) begin
        tmr_free_idx = IDX_W'(i);
      end
    end
  end

  assign free_found = (find_cls == CLS_TIMER) ? ~&tmr_used_r : ~&pin_used_r;
  assign free_idx   = (find_cls == CLS_TIMER) ? tmr_free_idx : pin_free_idx;

  // a timer entry that was never written still holds its reset contents
  assign ent.used  = (ent_cls == CLS_TIMER) ? tmr_used_r[ent_idx[TMR_AW-1:0]]
                                             : pin_used_r[ent_idx[PIN_AW-1:0]];
  assign ent.known = (ent_cls == CLS_TIMER) ? tmr_known_r[ent_idx[TMR_AW-1:0]] : 1'b1;

  always_comb begin
    pin_used_nxt  = pin_used_r;
    pin_sys_nxt   = pin_sys_r;
    tmr_used_nxt  = tmr_used_r;
    tmr_known_nxt = tmr_known_r;
    if (release_all) begin
      pin_used_nxt = pin_used_r & pin_sys_r;
    end else if (upd.set) begin
      if (upd.cls == CLS_TIMER) begin
        tmr_used_nxt[upd.idx[TMR_AW-1:0]]  = (upd.who != OWNER_FREE);
        tmr_known_nxt[upd.idx[TMR_AW-1:0]] = 1'b1;
      end else begin
        pin_used_nxt[upd.idx[PIN_AW-1:0]] = (upd.who != OWNER_FREE);
        pin_sys_nxt[upd.idx[PIN_AW-1:0]]  = (upd.who == OWNER_SYSTEM);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_used_r  <= '0;
      pin_sys_r   <= '0;
      tmr_used_r  <= TIMER_ENTRIES'(1);
      tmr_known_r <= '0;
    end else begin
      pin_used_r  <= pin_used_nxt;
      pin_sys_r   <= pin_sys_nxt;
      tmr_used_r  <= tmr_used_nxt;
      tmr_known_r <= tmr_known_nxt;
    end
  end

  a_release_keeps_sys_only: assert property (@(posedge clk) disable iff (!rst_n)
    release_all |=> (pin_used_r & ~pin_sys_r) == '0)
    else $error("release left a non-system pin held");

  a_sys_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
    (pin_sys_r & ~pin_used_r) == '0)
    else $error("system flag on a free pin");

  a_timer0_held: assert property (@(posedge clk) disable iff (!rst_n)
    tmr_used_r[0])
    else $error("timer 0 lost its system hold");

endmodule

@@ design/resource_ownership_lock_table.sv @@
// Top level of the resource ownership lock table: request sequencer, tables and result word.
// A request passes an accept cycle and an execute state: the accept cycle runs the first-free
// search on the occupancy bitmap and starts the table read; the execute state, held while the
// last result waits, compares the entry read back, writes it on a grant and loads the result
// word. A new request is taken in the cycle after that even while the previous result still
// waits. Owner codes and units live in one synchronous RAM per table; occupancy lives in
// flip-flop bitmaps, so reset and release-all take effect at once without a clearing pass.
module resource_ownership_lock_table
  import rolt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic               in_resource_class,
  input  logic               in_any_unit,
  input  logic [IDX_W-1:0]   in_requested_unit,
  input  logic [OWNER_W-1:0] in_requester,
  input  logic [UNIT_W-1:0]  in_requester_unit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_granted_unit,
  output logic [OWNER_W-1:0] out_holder,
  output logic [UNIT_W-1:0]  out_holder_unit,
  output logic               out_class_echo
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic               op_r, cls_r, any_r, found_r;
  logic [IDX_W-1:0]   req_idx_r, free_idx_r;
  logic [OWNER_W-1:0] who_r;
  logic [UNIT_W-1:0]  unit_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [OWNER_W-1:0] out_holder_r;
  logic [UNIT_W-1:0]  out_unit_r;
  logic               out_cls_r;

  logic               accept, exec_fire;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx, rd_idx, idx_sel;
  bm_entry_t          ent;
  bm_upd_t            upd;
  logic               release_all;
  logic [ENTRY_W-1:0] pin_rdata, tmr_rdata, rd_word;
  logic               pin_we, tmr_we, grant_new, in_range;
  logic [OWNER_W-1:0] cur_owner;
  logic [UNIT_W-1:0]  cur_unit;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_idx;
  logic [OWNER_W-1:0] res_holder;
  logic [UNIT_W-1:0]  res_unit;
  logic               res_cls;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign rd_idx  = in_any_unit ? free_idx : in_requested_unit;
  assign idx_sel = any_r ? free_idx_r : req_idx_r;

  rolt_bitmap u_bitmap (
    .clk         (clk),
    .rst_n       (rst_n),
    .find_cls    (in_resource_class),
    .free_found  (free_found),
    .free_idx    (free_idx),
    .ent_cls     (cls_r),
    .ent_idx     (idx_sel),
    .ent         (ent),
    .upd         (upd),
    .release_all (release_all)
  );

  rolt_ram #(.WIDTH(ENTRY_W), .DEPTH(PIN_ENTRIES)) u_pin_ram (
    .clk   (clk),
    .we    (pin_we),
    .waddr (idx_sel[PIN_AW-1:0]),
    .wdata ({who_r, unit_r}),
    .re    (accept),
    .raddr (rd_idx[PIN_AW-1:0]),
    .rdata (pin_rdata)
  );

  rolt_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_ENTRIES)) u_tmr_ram (
    .clk   (clk),
    .we    (tmr_we),
    .waddr (idx_sel[TMR_AW-1:0]),
    .wdata ({who_r, unit_r}),
    .re    (accept),
    .raddr (rd_idx[TMR_AW-1:0]),
    .rdata (tmr_rdata)
  );

  assign rd_word = (cls_r == CLS_TIMER) ? tmr_rdata : pin_rdata;
  // never-written timer entry: system owner if held, unit 0
  assign cur_owner = !ent.used ? OWNER_FREE :
                     (ent.known ? rd_word[ENTRY_W-1:UNIT_W] : OWNER_SYSTEM);
  assign cur_unit  = ent.known ? rd_word[UNIT_W-1:0] : '0;

  assign in_range = ({1'b0, req_idx_r} < ((cls_r == CLS_TIMER) ? (IDX_W + 1)'(TIMER_ENTRIES)
                                                               : (IDX_W + 1)'(PIN_ENTRIES)));

  always_comb begin
    grant_new  = 1'b0;
    res_status = ST_GRANTED;
    res_idx    = idx_sel;
    res_holder = '0;
    res_unit   = '0;
    res_cls    = cls_r;
    if (op_r == OP_RELEASE) begin
      res_idx = '0;
      res_cls = CLS_PIN;
    end else if (any_r && !found_r) begin
      res_status = ST_NONE_FREE;
      res_idx    = '0;
    end else if (!any_r && !in_range) begin
      res_status = ST_RANGE;
    end else if (!ent.used) begin
      grant_new  = 1'b1;
      res_holder = who_r;
      res_unit   = unit_r;
    end else begin
      res_holder = cur_owner;
      res_unit   = cur_unit;
      if (cur_owner != who_r || cur_unit != unit_r) begin
        res_status = ST_HELD;
      end
    end
  end

  assign pin_we      = exec_fire && grant_new && (cls_r == CLS_PIN);
  assign tmr_we      = exec_fire && grant_new && (cls_r == CLS_TIMER);
  assign release_all = exec_fire && (op_r == OP_RELEASE);
  assign upd.set     = exec_fire && grant_new;
  assign upd.cls     = cls_r;
  assign upd.idx     = idx_sel;
  assign upd.who     = who_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: if (exec_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_opcode;
      cls_r      <= in_resource_class;
      any_r      <= in_any_unit;
      req_idx_r  <= in_requested_unit;
      who_r      <= in_requester;
      unit_r     <= in_requester_unit;
      found_r    <= free_found;
      free_idx_r <= free_idx;
    end
    if (exec_fire) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_holder_r <= res_holder;
      out_unit_r   <= res_unit;
      out_cls_r    <= res_cls;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_unit = out_idx_r;
  assign out_holder       = out_holder_r;
  assign out_holder_unit  = out_unit_r;
  assign out_class_echo   = out_cls_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted word did not enter execute");

  a_write_is_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (pin_we || tmr_we) |=> out_valid_r && out_status_r == ST_GRANTED)
    else $error("table written without a grant");

  a_first_free_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == OP_LOCK && any_r && found_r) |-> !ent.used)
    else $error("first-free search picked a held entry");

endmodule

@@ sim/tb_resource_ownership_lock_table.sv @@
// Self-checking testbench for the resource ownership lock table: random and directed lock words.
`timescale 1ns / 100ps

module tb_resource_ownership_lock_table
  import rolt_pkg::*;
();

  localparam int RANDOM_ITEMS = 1850;
  localparam int CALM_TAIL    = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic               op;
    logic               cls;
    logic               any_u;
    logic [IDX_W-1:0]   req_idx;
    logic [OWNER_W-1:0] who;
    logic [UNIT_W-1:0]  who_unit;
  } lock_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   idx;
    logic [OWNER_W-1:0] holder;
    logic [UNIT_W-1:0]  holder_unit;
    logic               cls;
  } lock_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_opcode = OP_LOCK;
  logic               in_resource_class = CLS_PIN;
  logic               in_any_unit = 1'b0;
  logic [IDX_W-1:0]   in_requested_unit = '0;
  logic [OWNER_W-1:0] in_requester = OWNER_FREE;
  logic [UNIT_W-1:0]  in_requester_unit = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [IDX_W-1:0]   out_granted_unit;
  logic [OWNER_W-1:0] out_holder;
  logic [UNIT_W-1:0]  out_holder_unit;
  logic               out_class_echo;

  resource_ownership_lock_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_resource_class (in_resource_class),
    .in_any_unit       (in_any_unit),
    .in_requested_unit (in_requested_unit),
    .in_requester      (in_requester),
    .in_requester_unit (in_requester_unit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_unit  (out_granted_unit),
    .out_holder        (out_holder),
    .out_holder_unit   (out_holder_unit),
    .out_class_echo    (out_class_echo)
  );

  always #4 clk = ~clk;

  // shadow ownership tables, index 0 pins, index 1 timers
  logic [OWNER_W-1:0] owner_tab [2][PIN_ENTRIES];
  logic [UNIT_W-1:0]  unit_tab  [2][PIN_ENTRIES];

  lock_req_t request_q [$];
  lock_res_t pending_results [$];
  lock_req_t on_bus;
  int        in_count = 0;
  int        gap_cnt = 0;
  int        run_left = 0;
  int        stall_cnt = 0;
  int        free_cnt = 0;
  int        hold_cnt = 0;
  bit        pressure_done = 1'b0;
  bit        failed = 1'b0;
  int        cycle_cnt = 0;

  function automatic lock_res_t lock_table_outcome(lock_req_t r);
    lock_res_t          o;
    int                 n;
    int                 slot;
    logic [OWNER_W-1:0] cur_own;
    logic [UNIT_W-1:0]  cur_unit;
    o = '{status: ST_GRANTED, idx: '0, holder: OWNER_FREE, holder_unit: '0, cls: CLS_PIN};
    if (r.op == OP_RELEASE) begin
      for (int i = 0; i < PIN_ENTRIES; i++)
        if (owner_tab[CLS_PIN][i] != OWNER_SYSTEM) owner_tab[CLS_PIN][i] = OWNER_FREE;
      return o;
    end
    o.cls = r.cls;
    n = (r.cls == CLS_PIN) ? PIN_ENTRIES : TIMER_ENTRIES;
    if (r.any_u) begin
      slot = -1;
      for (int i = n - 1; i >= 0; i--)
        if (owner_tab[r.cls][i] == OWNER_FREE) slot = i;
      if (slot < 0) begin
        o.status = ST_NONE_FREE;
      end else begin
        owner_tab[r.cls][slot] = r.who;
        unit_tab[r.cls][slot]  = r.who_unit;
        o.idx         = slot[IDX_W-1:0];
        o.holder      = r.who;
        o.holder_unit = r.who_unit;
      end
      return o;
    end
    o.idx = r.req_idx;
    if (int'(r.req_idx) >= n) begin
      o.status = ST_RANGE;
      return o;
    end
    cur_own  = owner_tab[r.cls][r.req_idx];
    cur_unit = unit_tab[r.cls][r.req_idx];
    if (cur_own == OWNER_FREE) begin
      owner_tab[r.cls][r.req_idx] = r.who;
      unit_tab[r.cls][r.req_idx]  = r.who_unit;
      o.holder      = r.who;
      o.holder_unit = r.who_unit;
    end else begin
      // same owner and unit again is a grant, anything else is a conflict
      if (cur_own != r.who || cur_unit != r.who_unit) o.status = ST_HELD;
      o.holder      = cur_own;
      o.holder_unit = cur_unit;
    end
    return o;
  endfunction

  function automatic lock_req_t mk_req(logic op, logic cls, logic any_u, int idx, int who,
                                       int unit);
    lock_req_t r;
    r.op       = op;
    r.cls      = cls;
    r.any_u    = any_u;
    r.req_idx  = idx[IDX_W-1:0];
    r.who      = who[OWNER_W-1:0];
    r.who_unit = unit[UNIT_W-1:0];
    return r;
  endfunction

  // mostly ordinary owners; system, free and code 7 are rare
  function automatic int pick_owner();
    int k;
    k = $urandom_range(0, 39);
    if (k == 0) return OWNER_SYSTEM;
    if (k == 1) return OWNER_FREE;
    if (k == 2) return 7;
    return $urandom_range(2, 6);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // driver: one word on the bus at a time, gaps only between words
  always @(posedge clk) begin : drive
    lock_req_t nxt;
    logic      busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        pending_results.push_back(lock_table_outcome(on_bus));
        in_count++;
        busy = 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else if (request_q.size() >= CALM_TAIL && $urandom_range(0, 1) == 0) begin
          gap_cnt = $urandom_range(1, 17);
        end else begin
          run_left = $urandom_range(0, 30);
        end
      end
      if (!busy) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          on_bus = nxt;
          in_opcode         <= nxt.op;
          in_resource_class <= nxt.cls;
          in_any_unit       <= nxt.any_u;
          in_requested_unit <= nxt.req_idx;
          in_requester      <= nxt.who;
          in_requester_unit <= nxt.who_unit;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure, including one long hold-off
  always @(posedge clk) begin : sink
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (!pressure_done && in_count >= HOLD_AT) begin
      pressure_done = 1'b1;
      hold_cnt = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else if (free_cnt > 0) begin
      free_cnt--;
      out_ready <= 1'b1;
    end else if (request_q.size() >= CALM_TAIL && $urandom_range(0, 2) == 0) begin
      stall_cnt = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      free_cnt = $urandom_range(0, 40);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    lock_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d unit %0d", out_status, out_granted_unit);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("granted_unit", 32'(want.idx), 32'(out_granted_unit));
        check_field("holder", 32'(want.holder), 32'(out_holder));
        check_field("holder_unit", 32'(want.holder_unit), 32'(out_holder_unit));
        check_field("class_echo", 32'(want.cls), 32'(out_class_echo));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int        directed;
    int        len;
    int        kind;
    lock_req_t r;
    lock_req_t named_seen [$];

    for (int c = 0; c < 2; c++)
      for (int i = 0; i < PIN_ENTRIES; i++) begin
        owner_tab[c][i] = OWNER_FREE;
        unit_tab[c][i]  = '0;
      end
    owner_tab[CLS_TIMER][0] = OWNER_SYSTEM;

    // timer 0 belongs to the system from reset
    request_q.push_back(mk_req(OP_LOCK, CLS_TIMER, 1'b0, 0, OWNER_SYSTEM, 0));
    request_q.push_back(mk_req(OP_LOCK, CLS_TIMER, 1'b0, 0, 4, 3));
    request_q.push_back(mk_req(OP_LOCK, CLS_TIMER, 1'b0, TIMER_ENTRIES, 2, 1));
    request_q.push_back(mk_req(OP_LOCK, CLS_TIMER, 1'b0, 63, 5, 200));
    // fill the timers, then one more finds none free
    for (int i = 0; i < TIMER_ENTRIES - 1; i++)
      request_q.push_back(mk_req(OP_LOCK, CLS_TIMER, 1'b1, $urandom_range(0, 63),
                                 (i == 0) ? 7 : 2 + (i % 5), $urandom_range(0, 255)));
    request_q.push_back(mk_req(OP_LOCK, CLS_TIMER, 1'b1, 0, 3, 17));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b0, 63, 6, 255));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b0, 63, 6, 255));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b0, 63, 6, 254));
    // owner code 0 is granted but leaves the entry free
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b1, 0, OWNER_FREE, 8'hAA));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b0, 0, OWNER_SYSTEM, 0));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b1, 5, 3, 8'h55));
    request_q.push_back(mk_req(OP_RELEASE, CLS_TIMER, 1'b1, 63, 7, 255));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b0, 1, 2, 9));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b1, 0, 5, 1));
    request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b0, 0, 4, 0));
    request_q.push_back(mk_req(OP_RELEASE, CLS_PIN, 1'b0, 0, 0, 0));
    directed = request_q.size();

    while (request_q.size() < directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        // exhaust the pin table
        repeat (PIN_ENTRIES + 6)
          request_q.push_back(mk_req(OP_LOCK, CLS_PIN, 1'b1, $urandom_range(0, 63),
                                     $urandom_range(2, 7), $urandom_range(0, 255)));
      end else begin
        named_seen.delete();
        len = $urandom_range(3, 40);
        repeat (len) begin
          kind = $urandom_range(0, 99);
          if (kind < 35) begin
            r = mk_req(OP_LOCK, CLS_PIN, 1'b1, $urandom_range(0, 63), pick_owner(),
                       $urandom_range(0, 255));
          end else if (kind < 55) begin
            r = mk_req(OP_LOCK, CLS_PIN, 1'b0, $urandom_range(0, 63), pick_owner(),
                       $urandom_range(0, 255));
            named_seen.push_back(r);
          end else if (kind < 70 && named_seen.size() > 0) begin
            r = named_seen[$urandom_range(0, named_seen.size() - 1)];
            if ($urandom_range(0, 2) == 0) r.who_unit = UNIT_W'($urandom_range(0, 255));
            if ($urandom_range(0, 4) == 0) r.who = OWNER_W'(pick_owner());
          end else if (kind < 82) begin
            r = mk_req(OP_LOCK, CLS_TIMER, 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 15),
                       pick_owner(), $urandom_range(0, 255));
          end else if (kind < 95) begin
            r = mk_req(($urandom_range(0, 7) == 0) ? OP_RELEASE : OP_LOCK,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 255));
          end else begin
            r = mk_req(OP_RELEASE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 255));
          end
          request_q.push_back(r);
        end
      end
      request_q.push_back(mk_req(OP_RELEASE, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 63), $urandom_range(0, 7),
                                 $urandom_range(0, 255)));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
design/rolt_pkg.sv
design/rolt_ram.sv
design/rolt_bitmap.sv
design/resource_ownership_lock_table.sv
sim/tb_resource_ownership_lock_table.sv
